// File: src/cde_pkg.sv
// Shared types and constants for the column dictionary encoder.
// Depends on nothing; every other file of the block imports it.
package cde_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_NUM_COLUMNS = 16;
    localparam int DEF_DICT_DEPTH  = 256;
    localparam int DEF_VALUE_WIDTH = 32;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int TOL_W   = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

    // Register indexes (byte address divided by four).
    localparam logic [PADDR_W-3:0] REG_MATCH_TOLERANCE = 1'b0;

    typedef struct packed {
        logic [3:0]         column_index;
        logic signed [31:0] sample_value;
        logic               restart_column;
    } sample_word_t;

    typedef struct packed {
        logic [7:0] code;
        logic       is_new_entry;
        logic       overflow;
        logic [7:0] entry_count;
    } result_word_t;

endpackage

// File: src/cde_match_unit.sv
// Tolerance compare unit shared by every step of the dictionary search.
// Depends on cde_pkg for the tolerance width.
module cde_match_unit
    import cde_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic signed [VALUE_WIDTH-1:0] sample,
    input  logic signed [VALUE_WIDTH-1:0] entry,
    input  logic [TOL_W-1:0]              tolerance,
    output logic                          hit
);

    localparam int CMP_W = VALUE_WIDTH + TOL_W;

    logic signed [VALUE_WIDTH:0] diff;
    logic [VALUE_WIDTH:0]        neg_diff;
    logic [VALUE_WIDTH-1:0]      magnitude;

    // One extra bit keeps the difference free of overflow; its magnitude
    // always fits in VALUE_WIDTH bits.
    always_comb
    begin
        diff      = (VALUE_WIDTH+1)'(sample) - (VALUE_WIDTH+1)'(entry);
        neg_diff  = -diff;
        magnitude = diff[VALUE_WIDTH] ? neg_diff[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
        hit       = CMP_W'(magnitude) <= CMP_W'(tolerance);
    end

endmodule

// File: src/cde_cfg_regs.sv
// Configuration register file behind the APB-style port.
// Depends on cde_pkg for address decode and the tolerance reset value.
module cde_cfg_regs
    import cde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [TOL_W-1:0]   match_tolerance
);

    logic [TOL_W-1:0] tol_reg;
    logic [TOL_W-1:0] tol_next;
    logic             sel_tol;

    assign sel_tol = paddr[PADDR_W-1:2] == REG_MATCH_TOLERANCE;

    always_comb
    begin
        tol_next = tol_reg;
        if (psel && penable && pwrite && sel_tol)
        begin
            tol_next = pwdata[TOL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else
        begin
            tol_reg <= tol_next;
        end
    end

    assign prdata          = sel_tol ? PDATA_W'(tol_reg) : '0;
    assign pready          = 1'b1;
    assign match_tolerance = tol_reg;

endmodule

// File: src/column_dictionary_encoder_top.sv
// Top level of the column dictionary encoder: search sequencer, dictionary
// memory and per-column counts. Depends on cde_pkg, cde_match_unit, cde_cfg_regs.
//
// Usage
//   A sample word (column, Q16.16 value, restart bit) enters on the
//   sample_valid / sample_stall channel; one result word (code, new-entry
//   flag, overflow flag, entry count) leaves on result_valid / result_stall.
//   The block takes one sample at a time: sample_stall is high from the
//   accepting edge until the sequencer has finished that sample.
//   The dictionary row is searched one stored entry per cycle through a
//   single compare unit fed by the memory's registered read port; a column
//   holds at most 255 entries. A sample whose column lies outside the
//   configured range yields an all-zero word without a search.
//   The result sits in an output register; while the receiver stalls the
//   next sample is still accepted and searched, and the sequencer waits
//   only when it needs the output register for a second word.
//   Reset empties every column count and restores the tolerance to one;
//   the dictionary memory itself is not cleared, as only entries below a
//   column's count are ever compared. Configuration is to be written only
//   while idle; the block itself does not enforce this.
module column_dictionary_encoder_top
    import cde_pkg::*;
#(
    parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
    parameter int DICT_DEPTH  = DEF_DICT_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  sample_word_t       sample_word,
    output logic               result_valid,
    input  logic               result_stall,
    output result_word_t       result_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int IDX_W     = $clog2(DICT_DEPTH);
    localparam int COL_W     = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int MEM_DEPTH = NUM_COLUMNS * DICT_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [IDX_W-1:0] LAST_COUNT = IDX_W'(DICT_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ADDR_W-1:0]       base_reg, base_next;
    logic signed [VALUE_WIDTH-1:0] samp_reg, samp_next;
    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    result_word_t            res_reg, res_next;
    logic                    out_valid_reg, out_valid_next;
    result_word_t            out_word_reg, out_word_next;
    logic [IDX_W-1:0]        counts_reg [NUM_COLUMNS];

    logic [COL_W-1:0]        in_col;
    logic                    in_range;
    logic                    issue;
    logic                    hit;
    logic                    cnt_we;
    logic                    mem_we;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic [TOL_W-1:0]        match_tolerance;

    logic signed [VALUE_WIDTH-1:0] dict_mem [MEM_DEPTH];
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;

    cde_cfg_regs u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .match_tolerance (match_tolerance)
    );

    cde_match_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_match (
        .sample    (samp_reg),
        .entry     (rd_data_reg),
        .tolerance (match_tolerance),
        .hit       (hit)
    );

    assign in_col   = COL_W'(sample_word.column_index);
    assign in_range = 32'(sample_word.column_index) < NUM_COLUMNS;
    assign issue    = rd_idx_reg < cnt_reg;
    assign rd_addr  = base_reg + ADDR_W'(rd_idx_reg);
    assign wr_addr  = base_reg + ADDR_W'(cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        samp_next      = samp_reg;
        cnt_next       = cnt_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = rd_idx_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_word_next  = out_word_reg;
        cnt_we         = 1'b0;
        mem_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    col_next    = in_col;
                    base_next   = ADDR_W'(32'(in_col) * DICT_DEPTH);
                    samp_next   = VALUE_WIDTH'(sample_word.sample_value);
                    rd_idx_next = '0;
                    res_next    = '0;
                    if (in_range)
                    begin
                        cnt_next   = sample_word.restart_column ? '0 : counts_reg[in_col];
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_SEARCH:
            begin
                // Addresses run one ahead of the compare: the entry read in
                // one cycle is checked in the next.
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                pend_next = issue;
                if (pend_reg && hit)
                begin
                    res_next.code         = 8'(pend_idx_reg);
                    res_next.is_new_entry = 1'b0;
                    res_next.overflow     = 1'b0;
                    res_next.entry_count  = 8'(cnt_reg);
                    state_next            = ST_EMIT;
                end
                else if (!pend_reg && !issue)
                begin
                    if (cnt_reg == LAST_COUNT)
                    begin
                        res_next.code         = '0;
                        res_next.is_new_entry = 1'b0;
                        res_next.overflow     = 1'b1;
                        res_next.entry_count  = 8'(cnt_reg);
                    end
                    else
                    begin
                        mem_we                = 1'b1;
                        cnt_we                = 1'b1;
                        res_next.code         = 8'(cnt_reg);
                        res_next.is_new_entry = 1'b1;
                        res_next.overflow     = 1'b0;
                        res_next.entry_count  = 8'(cnt_reg + 1'b1);
                    end
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_word_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            for (int i = 0; i < NUM_COLUMNS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
            if (cnt_we)
            begin
                counts_reg[col_reg] <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        base_reg     <= base_next;
        samp_reg     <= samp_next;
        cnt_reg      <= cnt_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
    end

    // Dictionary memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dict_mem[wr_addr] <= samp_reg;
        end
        rd_data_reg <= dict_mem[rd_addr];
    end

    assign sample_stall = state_reg != ST_IDLE;
    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule
